// File: hw/rtl/cring_pkg.sv
// shared types, register codes and widths for the circle ring overlay
`default_nettype none

package cring_pkg;

    // widest image the block is sized for
    localparam int MAX_DIMENSION = 4096;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // intermediate widths
    localparam int DX_W    = 15;   // centre column minus pixel column
    localparam int DY_W    = 16;   // flipped centre row minus pixel row
    localparam int RAD_W   = 14;   // inner and outer radius
    localparam int SQ_W    = 29;   // squared distances and radii
    localparam int COLOR_W = 24;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    localparam cfg_index_t CFG_CENTER_COL     = 3'd0;
    localparam cfg_index_t CFG_CENTER_ROW_TOP = 3'd1;
    localparam cfg_index_t CFG_RADIUS         = 3'd2;
    localparam cfg_index_t CFG_THICKNESS      = 3'd3;
    localparam cfg_index_t CFG_RING_COLOR     = 3'd4;
    localparam cfg_index_t CFG_FILL_ENABLE    = 3'd5;
    localparam cfg_index_t CFG_FILL_COLOR     = 3'd6;
    localparam cfg_index_t CFG_IMAGE_HEIGHT   = 3'd7;

    typedef struct packed {
        logic [11:0] pixel_col;
        logic [11:0] pixel_row;
        logic [7:0]  red_in;
        logic [7:0]  green_in;
        logic [7:0]  blue_in;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } pixel_out_t;

    typedef struct packed {
        logic signed [13:0]   center_col;
        logic signed [13:0]   center_row_top;
        logic [12:0]          radius;
        logic [11:0]          thickness;
        logic [COLOR_W-1:0]   ring_color;
        logic                 fill_enable;
        logic [COLOR_W-1:0]   fill_rgb;
        logic [12:0]          image_height;
    } cfg_t;

    // register values after reset: all zero but thickness and image height
    localparam cfg_t CFG_RESET =
        cfg_t'({14'd0, 14'd0, 13'd0, 12'd1, 24'd0, 1'b0, 24'd0, 13'd1});

    // geometry of one pixel handed from the distance pipe to the shading stage
    typedef struct packed {
        logic [SQ_W-1:0]    d2;
        logic [SQ_W-1:0]    in2;
        logic [SQ_W-1:0]    out2;
        logic               inner_pos;
        logic               in_range;
        logic [COLOR_W-1:0] color;
    } dist_t;

endpackage

`default_nettype wire

// File: hw/rtl/cring_cfg.sv
// configuration register file for the circle ring overlay
`default_nettype none

module cring_cfg
    import cring_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire cfg_index_t            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_CENTER_COL:     cfg_next.center_col     = signed'(cfg_data[13:0]);
                CFG_CENTER_ROW_TOP: cfg_next.center_row_top = signed'(cfg_data[13:0]);
                CFG_RADIUS:         cfg_next.radius         = cfg_data[12:0];
                CFG_THICKNESS:      cfg_next.thickness      = cfg_data[11:0];
                CFG_RING_COLOR:     cfg_next.ring_color     = cfg_data[COLOR_W-1:0];
                CFG_FILL_ENABLE:    cfg_next.fill_enable    = cfg_data[0];
                CFG_FILL_COLOR:     cfg_next.fill_rgb       = cfg_data[COLOR_W-1:0];
                CFG_IMAGE_HEIGHT:   cfg_next.image_height   = cfg_data[12:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: hw/rtl/cring_dist.sv
// three stage pipe: offsets and radii, squares, squared distance sum
`default_nettype none

module cring_dist
    import cring_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cfg_t      cfg,
    input  wire logic      up_valid,
    output logic           up_ready,
    input  wire pixel_in_t up_data,
    output logic           dn_valid,
    input  wire logic      dn_ready,
    output dist_t          dn_data
);

    // stage 1: offsets from the centre, inner and outer radius
    logic                     s1_valid_reg;
    logic signed [DX_W-1:0]   s1_dx_reg;
    logic signed [DY_W-1:0]   s1_dy_reg;
    logic signed [RAD_W-1:0]  s1_inner_reg;
    logic [RAD_W-1:0]         s1_outer_reg;
    logic                     s1_in_range_reg;
    logic [COLOR_W-1:0]       s1_color_reg;

    // stage 2: squares
    logic                     s2_valid_reg;
    logic [SQ_W-1:0]          s2_dx2_reg;
    logic [SQ_W-1:0]          s2_dy2_reg;
    logic [SQ_W-1:0]          s2_in2_reg;
    logic [SQ_W-1:0]          s2_out2_reg;
    logic                     s2_inner_pos_reg;
    logic                     s2_in_range_reg;
    logic [COLOR_W-1:0]       s2_color_reg;

    // stage 3: sum
    logic                     s3_valid_reg;
    dist_t                    s3_data_reg;

    logic s1_ready;
    logic s2_ready;
    logic s3_ready;

    logic signed [DY_W-1:0]   cy;
    logic signed [DX_W-1:0]   dx_next;
    logic signed [DY_W-1:0]   dy_next;
    logic [10:0]              half;
    logic [11:0]              half_up;
    logic signed [RAD_W-1:0]  inner_next;
    logic [RAD_W-1:0]         outer_next;
    logic                     in_range_next;

    logic signed [2*DX_W-1:0]  dx_sq;
    logic signed [2*DY_W-1:0]  dy_sq;
    logic signed [2*RAD_W-1:0] in_sq;
    logic [2*RAD_W-1:0]        out_sq;
    logic                      inner_pos_next;

    dist_t                     s3_next;

    assign s3_ready = !s3_valid_reg || dn_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign up_ready = s1_ready;

    always_comb
    begin
        // centre row flipped to bottom-up storage order
        cy = signed'({3'b000, cfg.image_height}) - 16'sd1
             - signed'({{2{cfg.center_row_top[13]}}, cfg.center_row_top});
        dx_next = signed'({cfg.center_col[13], cfg.center_col})
                  - signed'({3'b000, up_data.pixel_col});
        dy_next = cy - signed'({4'b0000, up_data.pixel_row});
        half       = cfg.thickness[11:1];
        half_up    = cfg.thickness - {1'b0, half};
        inner_next = signed'({1'b0, cfg.radius}) - signed'({3'b000, half});
        outer_next = {1'b0, cfg.radius} + {2'b00, half_up};
        in_range_next = ({20'd0, up_data.pixel_col} < 32'(MAX_DIMENSION));
    end

    always_comb
    begin
        dx_sq  = s1_dx_reg * s1_dx_reg;
        dy_sq  = s1_dy_reg * s1_dy_reg;
        in_sq  = s1_inner_reg * s1_inner_reg;
        out_sq = s1_outer_reg * s1_outer_reg;
        inner_pos_next = !s1_inner_reg[RAD_W-1] && (|s1_inner_reg);
    end

    always_comb
    begin
        s3_next.d2        = s2_dx2_reg + s2_dy2_reg;
        s3_next.in2       = s2_in2_reg;
        s3_next.out2      = s2_out2_reg;
        s3_next.inner_pos = s2_inner_pos_reg;
        s3_next.in_range  = s2_in_range_reg;
        s3_next.color     = s2_color_reg;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= up_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s1_ready && up_valid)
        begin
            s1_dx_reg       <= dx_next;
            s1_dy_reg       <= dy_next;
            s1_inner_reg    <= inner_next;
            s1_outer_reg    <= outer_next;
            s1_in_range_reg <= in_range_next;
            s1_color_reg    <= {up_data.red_in, up_data.green_in, up_data.blue_in};
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_dx2_reg       <= {1'b0, dx_sq[27:0]};
            s2_dy2_reg       <= {1'b0, dy_sq[27:0]};
            s2_in2_reg       <= {3'b000, in_sq[25:0]};
            s2_out2_reg      <= {2'b00, out_sq[26:0]};
            s2_inner_pos_reg <= inner_pos_next;
            s2_in_range_reg  <= s1_in_range_reg;
            s2_color_reg     <= s1_color_reg;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_data_reg <= s3_next;
        end
    end

    assign dn_valid = s3_valid_reg;
    assign dn_data  = s3_data_reg;

endmodule

`default_nettype wire

// File: hw/rtl/cring_shade.sv
// ring and fill tests, colour select and output register
`default_nettype none

module cring_shade
    import cring_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  up_valid,
    output logic       up_ready,
    input  wire dist_t up_data,
    output logic       out_valid,
    input  wire logic  out_ready,
    output pixel_out_t out_data
);

    logic               out_valid_reg;
    logic [COLOR_W-1:0] color_reg;
    logic [COLOR_W-1:0] color_next;
    logic               in_fill;
    logic               in_ring;

    assign up_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        in_fill = cfg.fill_enable && (up_data.d2 < up_data.in2);
        in_ring = (up_data.d2 < up_data.out2)
                  && (!up_data.inner_pos || (up_data.d2 >= up_data.in2));
        color_next = up_data.color;
        if (up_data.in_range)
        begin
            if (in_ring)
            begin
                color_next = cfg.ring_color;
            end
            else if (in_fill)
            begin
                color_next = cfg.fill_rgb;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            out_valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            color_reg <= color_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign out_data.red_out   = color_reg[23:16];
    assign out_data.green_out = color_reg[15:8];
    assign out_data.blue_out  = color_reg[7:0];

endmodule

`default_nettype wire

// File: hw/rtl/circle_ring_pixel_overlay_core.sv
// top level of the circle ring pixel overlay
// usage:
// - pixels arrive on in_valid / in_ready / in_data, one request per pixel,
//   carrying column, bottom-up storage row and rgb value
// - each pixel leaves on out_valid / out_ready / out_data, either unchanged,
//   in the fill colour (interior, when enabled) or in the ring colour
// - eight registers are written through cfg_we / cfg_index / cfg_data with no
//   wait; write them only while no request is in flight
// - a new request is taken every cycle unless the receiver stalls and
//   every stage holds a request
// - the four register stages are: offsets and radii, squares (one multiplier
//   per term), squared distance sum, compare and colour select
// - a stalled receiver holds the output register; the stall passes back
//   through the combinational ready chain, so nothing is lost or repeated
//   and in_ready drops only once every stage holds a request
// - reset clears every valid bit and loads the register defaults: all zero
//   but thickness and image height, which come up as one
`default_nettype none

module circle_ring_pixel_overlay_core
    import cring_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration write port
    input  wire logic                  cfg_we,
    input  wire cfg_index_t            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // pixel requests in
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire pixel_in_t             in_data,
    // recoloured pixels out
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output pixel_out_t                 out_data
);

    cfg_t  cfg;
    logic  dist_valid;
    logic  dist_ready;
    dist_t dist_data;

    // register file
    cring_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // distance pipe, first three stages
    cring_dist u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .up_valid (in_valid),
        .up_ready (in_ready),
        .up_data  (in_data),
        .dn_valid (dist_valid),
        .dn_ready (dist_ready),
        .dn_data  (dist_data)
    );

    // compare, select, output register
    cring_shade u_shade (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .up_valid  (dist_valid),
        .up_ready  (dist_ready),
        .up_data   (dist_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
